// ----- hdl/fmm_pkg.sv -----
// Shared types, register indexes, reset values and the sine table for the FM modulator.
package fmm_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_FM_STEP      = 3'd0;
  localparam logic [2:0] CFG_MIC_GAIN     = 3'd1;
  localparam logic [2:0] CFG_METER_PERIOD = 3'd2;
  localparam logic [2:0] CFG_CTCSS_ON     = 3'd3;
  localparam logic [2:0] CFG_CTCSS_STEP   = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register reset values
  localparam logic [23:0] RST_FM_STEP      = 24'd0;
  localparam logic [7:0]  RST_MIC_GAIN     = 8'd10;
  localparam logic [15:0] RST_METER_PERIOD = 16'd4096;
  localparam logic        RST_CTCSS_ON     = 1'b0;
  localparam logic [31:0] RST_CTCSS_STEP   = 32'd0;

  // Divide by ten: (m * 52429) >> 19 is exact for m below 43690
  localparam logic [31:0] DIV10_RECIP = 32'd52429;

  // Mixing weights for voice and tone
  localparam logic signed [21:0] MIX_VOICE_W = 22'sd205;
  localparam logic signed [21:0] MIX_TONE_W  = 22'sd50;

  // Quarter turn in units of the top phase byte
  localparam logic [7:0] QUARTER_TURN = 8'd64;

  // Level report saturation value
  localparam logic [15:0] LEVEL_MAX = 16'hFFFF;

  // Commands from the controller to the datapath, one step each
  typedef struct packed {
    logic load;      // capture the incoming sample
    logic gain;      // shifted sample times gain
    logic scale;     // divide by ten
    logic mix;       // meter update, tone mix, tone phase advance
    logic mixed;     // scale mix down by 256
    logic fm_mul;    // mixed sample times fm step
    logic phase;     // advance carrier phase
    logic out_load;  // load the result register
  } fmm_cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic div_busy;
  } fmm_sts_t;

  // First quadrant of round(127*sin(2*pi*k/256)), k = 0..64
  localparam logic [6:0] QSINE [0:64] = '{
    7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd16,  7'd19,  7'd22,
    7'd25,  7'd28,  7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,
    7'd49,  7'd51,  7'd54,  7'd57,  7'd60,  7'd63,  7'd65,  7'd68,
    7'd71,  7'd73,  7'd76,  7'd78,  7'd81,  7'd83,  7'd85,  7'd88,
    7'd90,  7'd92,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd104,
    7'd106, 7'd107, 7'd109, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116,
    7'd117, 7'd118, 7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124,
    7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127,
    7'd127
  };

  // Signed 8-bit sine of the top phase byte, folded from the quadrant table
  function automatic logic signed [7:0] fmm_sine(input logic [7:0] idx);
    logic [1:0] quad;
    logic [5:0] r;
    logic [6:0] ti;
    logic [7:0] v;
    quad = idx[7:6];
    r    = idx[5:0];
    ti   = quad[0] ? (7'd64 - {1'b0, r}) : {1'b0, r};
    v    = {1'b0, QSINE[ti]};
    return quad[1] ? $signed(-v) : $signed(v);
  endfunction

endpackage

// ----- hdl/fmm_div.sv -----
// Restoring divider, one quotient bit per cycle, for the level meter.
module fmm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [13:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);
  logic        busy_r, busy_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [13:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [13:0] dsr_r, dsr_nxt;
  logic [14:0] rem_sh;
  logic [14:0] trial;
  logic        fits;

  // One restoring step
  assign rem_sh = {rem_r, quo_r[31]};
  assign trial  = rem_sh - {1'b0, dsr_r};
  assign fits   = (rem_sh >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd31;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? trial[13:0] : rem_sh[13:0];
      quo_nxt = {quo_r[30:0], fits};
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operands, no reset needed
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;
endmodule

// ----- hdl/fmm_dp.sv -----
// Datapath: config registers, sample scaling, tone mix, phase accumulators, meter, result register.
module fmm_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [fmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fmm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic signed [15:0]             in_audio_sample,
  input  fmm_pkg::fmm_cmd_t              cmd,
  output fmm_pkg::fmm_sts_t              sts,
  output logic signed [7:0]              out_i_out,
  output logic signed [7:0]              out_q_out,
  output logic [15:0]                    out_level,
  output logic                           out_level_valid
);
  import fmm_pkg::*;

  // Configuration registers
  logic [23:0] fm_step_r;
  logic [7:0]  gain_r;
  logic [15:0] period_r;
  logic        ctcss_on_r;
  logic [31:0] ctcss_step_r;

  // Architectural state
  logic [31:0] carrier_r, carrier_nxt;
  logic [31:0] tone_ph_r, tone_ph_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [15:0] cnt_r, cnt_nxt;

  // Pipeline registers
  logic signed [15:0] smp_in_r;
  logic signed [16:0] gprod_r;
  logic signed [12:0] sample_r;
  logic [11:0]        smag_r;
  logic signed [21:0] mix_sum_r;
  logic signed [12:0] mixed_r;
  logic [31:0]        pprod_r;
  logic               rep_r;
  logic               divz_r;

  // Result register
  logic signed [7:0] i_r, q_r;
  logic [15:0]       level_r;
  logic              lv_r;

  logic signed [7:0]  shifted;
  logic signed [16:0] gprod_nxt;
  logic [16:0]        gabs;
  logic [31:0]        qprod;
  logic [11:0]        q10;
  logic signed [12:0] sample_nxt;
  logic signed [7:0]  tone;
  logic signed [21:0] mix_nxt;
  logic signed [21:0] mix_adj;
  logic signed [12:0] mixed_nxt;
  logic signed [37:0] pfull;
  logic [31:0]        sum_new;
  logic [13:0]        div_base;
  logic               rep;
  logic               divz;
  logic               div_start;
  logic               div_busy;
  logic [31:0]        div_quo;
  logic               fm_on;
  logic [7:0]         ph_top;
  logic [15:0]        level_nxt;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fm_step_r    <= RST_FM_STEP;
      gain_r       <= RST_MIC_GAIN;
      period_r     <= RST_METER_PERIOD;
      ctcss_on_r   <= RST_CTCSS_ON;
      ctcss_step_r <= RST_CTCSS_STEP;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FM_STEP:      fm_step_r    <= cfg_wdata[23:0];
        CFG_MIC_GAIN:     gain_r       <= cfg_wdata[7:0];
        CFG_METER_PERIOD: period_r     <= cfg_wdata[15:0];
        CFG_CTCSS_ON:     ctcss_on_r   <= cfg_wdata[0];
        CFG_CTCSS_STEP:   ctcss_step_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Gain: floor shift by 8 is the top byte, times gain
  assign shifted   = smp_in_r[15:8];
  assign gprod_nxt = shifted * $signed({1'b0, gain_r});

  // Divide by ten toward zero on the magnitude
  assign gabs       = gprod_r[16] ? 17'(-gprod_r) : gprod_r;
  assign qprod      = 32'(gabs[15:0]) * DIV10_RECIP;
  assign q10        = qprod[30:19];
  assign sample_nxt = gprod_r[16] ? -$signed({1'b0, q10}) : $signed({1'b0, q10});

  // Tone mix
  assign tone    = fmm_sine(tone_ph_r[31:24]);
  assign mix_nxt = sample_r * MIX_VOICE_W + tone * MIX_TONE_W;

  // Divide mix by 256 toward zero, or pass the voice when the tone is off
  assign mix_adj   = mix_sum_r + (mix_sum_r[21] ? 22'sd255 : 22'sd0);
  assign mixed_nxt = ctcss_on_r ? mix_adj[20:8] : sample_r;

  // Phase increment, modulo 2^32
  assign pfull = mixed_r * $signed({1'b0, fm_step_r});
  assign fm_on = (fm_step_r != 24'd0);

  // Meter
  assign sum_new   = sum_r + 32'(smag_r);
  assign div_base  = period_r[15:2];
  assign divz      = (div_base == 14'd0);
  assign rep       = (cnt_r == 16'd0);
  assign div_start = cmd.mix && rep && !divz;

  always_comb begin
    carrier_nxt = carrier_r;
    tone_ph_nxt = tone_ph_r;
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    if (cmd.mix) begin
      if (rep) begin
        sum_nxt = '0;
        cnt_nxt = period_r;
      end else begin
        sum_nxt = sum_new;
        cnt_nxt = cnt_r - 16'd1;
      end
      if (ctcss_on_r) begin
        tone_ph_nxt = tone_ph_r + ctcss_step_r;
      end
    end
    if (cmd.phase && fm_on) begin
      carrier_nxt = carrier_r + pprod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_r <= '0;
      tone_ph_r <= '0;
      sum_r     <= '0;
      cnt_r     <= '0;
    end else begin
      carrier_r <= carrier_nxt;
      tone_ph_r <= tone_ph_nxt;
      sum_r     <= sum_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // Pipeline steps
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_in_r <= in_audio_sample;
    end
    if (cmd.gain) begin
      gprod_r <= gprod_nxt;
    end
    if (cmd.scale) begin
      sample_r <= sample_nxt;
      smag_r   <= q10;
    end
    if (cmd.mix) begin
      mix_sum_r <= mix_nxt;
      rep_r     <= rep;
      divz_r    <= divz;
    end
    if (cmd.mixed) begin
      mixed_r <= mixed_nxt;
    end
    if (cmd.fm_mul) begin
      pprod_r <= pfull[31:0];
    end
  end

  fmm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_new),
    .divisor  (div_base),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Level report with saturation
  always_comb begin
    level_nxt = '0;
    if (rep_r) begin
      if (divz_r || (div_quo[31:16] != 16'd0)) begin
        level_nxt = LEVEL_MAX;
      end else begin
        level_nxt = div_quo[15:0];
      end
    end
  end

  // Result register
  assign ph_top = carrier_r[31:24];
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      i_r     <= fm_on ? fmm_sine(ph_top + QUARTER_TURN) : 8'sd0;
      q_r     <= fm_on ? fmm_sine(ph_top) : 8'sd0;
      level_r <= level_nxt;
      lv_r    <= rep_r;
    end
  end

  assign sts.div_busy    = div_busy;
  assign out_i_out       = i_r;
  assign out_q_out       = q_r;
  assign out_level       = level_r;
  assign out_level_valid = lv_r;
endmodule

// ----- hdl/fmm_ctrl.sv -----
// Controller: sequences one request through the datapath and owns the handshakes.
module fmm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output fmm_pkg::fmm_cmd_t cmd,
  input  fmm_pkg::fmm_sts_t sts
);
  import fmm_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_GAIN   = 3'd1;
  localparam logic [2:0] S_SCALE  = 3'd2;
  localparam logic [2:0] S_MIX    = 3'd3;
  localparam logic [2:0] S_MIXED  = 3'd4;
  localparam logic [2:0] S_FMMUL  = 3'd5;
  localparam logic [2:0] S_PHASE  = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       ovld_r, ovld_nxt;
  logic       slot_free;

  // Result slot is free when empty or being taken this cycle
  assign slot_free = !ovld_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd.gain  = 1'b1;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = S_MIXED;
      end
      S_MIXED: begin
        cmd.mixed = 1'b1;
        state_nxt = S_FMMUL;
      end
      S_FMMUL: begin
        cmd.fm_mul = 1'b1;
        state_nxt  = S_PHASE;
      end
      S_PHASE: begin
        cmd.phase = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // wait for the level divider and a free result slot
        if (!sts.div_busy && slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid flag
  always_comb begin
    ovld_nxt = ovld_r;
    if (cmd.out_load) begin
      ovld_nxt = 1'b1;
    end else if (ovld_r && !out_stall) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovld_r;
endmodule

// ----- hdl/fm_modulator_with_ctcss_and_meter.sv -----
// FM modulator with CTCSS tone and level meter: top level.
// Each request carries one signed 16-bit microphone sample and yields one I/Q pair
// plus an optional level report. A request is finished before the next one is
// accepted; on a tick that carries a level report it also waits for the 32-step
// restoring divider that forms sum / (meter_period/4). The result
// sits in an output register, so a new sample is taken while the last result waits
// to be read. Config registers are written through cfg_wr_en/cfg_index/cfg_wdata
// and must only be changed while no request is in flight.
module fm_modulator_with_ctcss_and_meter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [fmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fmm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [15:0]             in_audio_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [7:0]              out_i_out,
  output logic signed [7:0]              out_q_out,
  output logic [15:0]                    out_level,
  output logic                           out_level_valid
);
  import fmm_pkg::*;

  fmm_cmd_t cmd;
  fmm_sts_t sts;

  fmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  fmm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_audio_sample (in_audio_sample),
    .cmd             (cmd),
    .sts             (sts),
    .out_i_out       (out_i_out),
    .out_q_out       (out_q_out),
    .out_level       (out_level),
    .out_level_valid (out_level_valid)
  );

  // An accepted request keeps the input side busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepting a request");

  // At most one datapath step per cycle
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command active");

  // Without a report the level field is zero
  a_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_level_valid |-> out_level == 16'd0)
    else $error("level nonzero without report");

  // A result only appears at the end of a request's processing
  a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in progress");
endmodule

// ----- tb/fm_modulator_with_ctcss_and_meter_tb.sv -----
// Self-checking testbench for the FM modulator with CTCSS tone and level meter.
module fm_modulator_with_ctcss_and_meter_tb;
  import fmm_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic signed [15:0]    in_audio_sample;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [7:0]     out_i_out;
  logic signed [7:0]     out_q_out;
  logic [15:0]           out_level;
  logic                  out_level_valid;

  // One I/Q tick as it leaves the block
  typedef struct packed {
    logic signed [7:0] i;
    logic signed [7:0] q;
    logic [15:0]       level;
    logic              lv;
  } iq_res_t;

  // Directed stimulus row: either a register write or a run of identical samples
  typedef struct {
    bit                 is_cfg;
    logic [2:0]         idx;
    logic [31:0]        val;
    logic signed [15:0] smp;
    int                 reps;
    bit                 typed;
    iq_res_t            want;
  } plan_row_t;

  // Shadow copy of the registers
  logic [23:0] fm_inc    = 24'd0;
  logic [7:0]  gain      = 8'd10;
  logic [15:0] meter_per = 16'd4096;
  logic        tone_en   = 1'b0;
  logic [31:0] tone_inc  = 32'd0;

  // Modulator and meter state
  logic [31:0] car_ph    = 32'd0;
  logic [31:0] tone_ph   = 32'd0;
  logic [31:0] mag_sum   = 32'd0;
  logic [15:0] countdown = 16'd0;

  iq_res_t   pending_q[$];
  plan_row_t plan[$];
  int        errors = 0;
  bit        quiet  = 1'b0;

  // First quadrant of the 8-bit sine
  int quarter_tab [65] = '{
    0,   3,   6,   9,   12,  16,  19,  22,  25,  28,  31,  34,  37,  40,  43,  46,
    49,  51,  54,  57,  60,  63,  65,  68,  71,  73,  76,  78,  81,  83,  85,  88,
    90,  92,  94,  96,  98,  100, 102, 104, 106, 107, 109, 111, 112, 113, 115, 116,
    117, 118, 120, 121, 122, 122, 123, 124, 125, 125, 126, 126, 126, 127, 127, 127,
    127
  };

  fm_modulator_with_ctcss_and_meter uut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report(input string msg);
    if (errors < 40) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  // Sine of the top phase byte, folded from the quadrant table
  function automatic int sine_lut(input logic [31:0] ph);
    logic [7:0] idx;
    int         v;
    idx = ph[31:24];
    v   = idx[6] ? quarter_tab[64 - idx[5:0]] : quarter_tab[idx[5:0]];
    return idx[7] ? -v : v;
  endfunction

  // Advance the modulator by one sample and return the I/Q tick it yields
  function automatic iq_res_t modulate_tick(input logic signed [15:0] s);
    int          shifted;
    int          scaled;
    int          mixed;
    int          tone;
    logic [31:0] div;
    logic [31:0] quo;
    logic [31:0] mix_u;
    iq_res_t     r;
    r       = '0;
    shifted = int'(s) >>> 8;
    scaled  = (shifted * int'(gain)) / 10;
    // level meter
    mag_sum = mag_sum + ((scaled < 0) ? -scaled : scaled);
    if (countdown == 16'd0) begin
      div       = {16'd0, meter_per} >> 2;
      quo       = (div == 32'd0) ? 32'd65535 : mag_sum / div;
      r.level   = (quo > 32'd65535) ? 16'hFFFF : quo[15:0];
      r.lv      = 1'b1;
      countdown = meter_per;
      mag_sum   = 32'd0;
    end else begin
      countdown = countdown - 16'd1;
    end
    // subaudible tone mix
    if (tone_en) begin
      tone    = sine_lut(tone_ph);
      mixed   = (scaled * 205 + tone * 50) / 256;
      tone_ph = tone_ph + tone_inc;
    end else begin
      mixed = scaled;
    end
    // carrier phase and I/Q lookup; zero step leaves the phase alone
    if (fm_inc != 24'd0) begin
      mix_u  = mixed;
      car_ph = car_ph + mix_u * {8'd0, fm_inc};
      r.i    = 8'(sine_lut(car_ph + 32'h4000_0000));
      r.q    = 8'(sine_lut(car_ph));
    end
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_FM_STEP:      fm_inc    = val[23:0];
      CFG_MIC_GAIN:     gain      = val[7:0];
      CFG_METER_PERIOD: meter_per = val[15:0];
      CFG_CTCSS_ON:     tone_en   = val[0];
      CFG_CTCSS_STEP:   tone_inc  = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Hold off until every pending tick has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random sender gap, short mostly, now and then long enough to span a report
  task automatic gap();
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 45 : 8)) @(posedge clk);
    end
  endtask

  // Present one request and record its expected tick once it is taken
  task automatic send_sample(input logic signed [15:0] s, input bit typed,
                             input iq_res_t want);
    iq_res_t got;
    in_valid        <= 1'b1;
    in_audio_sample <= s;
    do @(posedge clk); while (in_stall);
    got = modulate_tick(s);
    pending_q.push_back(typed ? want : got);
  endtask

  function automatic void row_cfg(input logic [2:0] idx, input logic [31:0] val);
    plan_row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    r.smp    = '0;
    r.reps   = 0;
    r.typed  = 1'b0;
    r.want   = '0;
    plan.push_back(r);
  endfunction

  function automatic void row_smp(input logic signed [15:0] s, input int reps,
                                  input bit typed, input iq_res_t want);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = '0;
    r.val    = '0;
    r.smp    = s;
    r.reps   = reps;
    r.typed  = typed;
    r.want   = want;
    plan.push_back(r);
  endfunction

  // Result receiver stalls at random, except in the quiet stretch
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 8);
  end

  // Compare each accepted tick with the oldest pending one
  always @(posedge clk) begin : check_out
    iq_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report("tick with no request pending");
      end else begin
        want = pending_q.pop_front();
        if (out_i_out !== want.i)
          report($sformatf("i_out %0d, want %0d", out_i_out, want.i));
        if (out_q_out !== want.q)
          report($sformatf("q_out %0d, want %0d", out_q_out, want.q));
        if (out_level !== want.level)
          report($sformatf("level %0d, want %0d", out_level, want.level));
        if (out_level_valid !== want.lv)
          report($sformatf("level_valid %0b, want %0b", out_level_valid, want.lv));
      end
    end
  end

  initial begin : stim
    iq_res_t            sat_tick;
    bit                 prev_cfg;
    int                 n;
    int                 k;
    int                 total;
    int                 phase;
    bit                 last;
    logic signed [15:0] s;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_audio_sample = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    sat_tick = '{i: 8'sd0, q: 8'sd0, level: 16'hFFFF, lv: 1'b1};
    // zero divisor from the first tick after reset, zero FM step
    row_cfg(CFG_METER_PERIOD, 32'd0);
    row_smp(16'sd32767, 1, 1'b1, sat_tick);
    row_smp(-16'sd32768, 1, 1'b1, sat_tick);
    row_smp(16'sd0, 1, 1'b1, sat_tick);
    // full step and gain, wide phase product, sample extremes
    row_cfg(CFG_FM_STEP, 32'h00FF_FFFF);
    row_cfg(CFG_MIC_GAIN, 32'd255);
    row_cfg(CFG_METER_PERIOD, 32'd4);
    row_smp(16'sd0, 1, 1'b0, '0);
    row_smp(16'sd32767, 1, 1'b0, '0);
    row_smp(-16'sd32768, 1, 1'b0, '0);
    row_smp(-16'sd1, 1, 1'b0, '0);
    row_smp(16'sd255, 1, 1'b0, '0);
    row_smp(-16'sd256, 1, 1'b0, '0);
    // tone alone: voice gain zero, tone step at its top
    row_cfg(CFG_CTCSS_ON, 32'd1);
    row_cfg(CFG_CTCSS_STEP, 32'hFFFF_FFFF);
    row_cfg(CFG_MIC_GAIN, 32'd0);
    row_cfg(CFG_FM_STEP, 32'd1);
    row_smp(16'sd12345, 4, 1'b0, '0);
    // build a large sum over a long period, then report it with divisor one
    row_cfg(CFG_MIC_GAIN, 32'd255);
    row_cfg(CFG_CTCSS_STEP, 32'h0400_0000);
    row_cfg(CFG_FM_STEP, 32'h0000_1234);
    row_cfg(CFG_METER_PERIOD, 32'd20);
    row_smp(-16'sd32768, 21, 1'b0, '0);
    row_cfg(CFG_METER_PERIOD, 32'd4);
    row_smp(-16'sd32768, 1, 1'b0, '0);
    // tone off, step zero, no report pending
    row_cfg(CFG_CTCSS_ON, 32'd0);
    row_cfg(CFG_FM_STEP, 32'd0);
    row_smp(16'sd32767, 2, 1'b1, '0);

    prev_cfg = 1'b0;
    foreach (plan[n]) begin
      if (plan[n].is_cfg) begin
        if (!prev_cfg) drain();
        write_reg(plan[n].idx, plan[n].val);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg_wr_en <= 1'b0;
        prev_cfg = 1'b0;
        for (k = 0; k < plan[n].reps; k++) begin
          gap();
          send_sample(plan[n].smp, plan[n].typed, plan[n].want);
        end
      end
    end

    // Random phases, each after the pipe has emptied
    total = 0;
    phase = 0;
    while (total < 1050) begin
      drain();
      n    = $urandom_range(10, 60);
      last = (total + n >= 1050);
      if (phase == 0 || $urandom_range(1)) begin
        case ($urandom_range(4))
          0:       write_reg(CFG_FM_STEP, 32'd0);
          1:       write_reg(CFG_FM_STEP, 32'h00FF_FFFF);
          2:       write_reg(CFG_FM_STEP, $urandom_range(1, 255));
          default: write_reg(CFG_FM_STEP, {8'd0, 24'($urandom)});
        endcase
      end
      if (phase == 0 || $urandom_range(1)) begin
        case ($urandom_range(3))
          0:       write_reg(CFG_MIC_GAIN, 32'd0);
          1:       write_reg(CFG_MIC_GAIN, 32'd255);
          2:       write_reg(CFG_MIC_GAIN, 32'd10);
          default: write_reg(CFG_MIC_GAIN, $urandom_range(255));
        endcase
      end
      // long periods only at the end; otherwise reports would stop for good
      if (last)
        write_reg(CFG_METER_PERIOD, 32'd65535);
      else if (phase == 0 || $urandom_range(1))
        write_reg(CFG_METER_PERIOD, ($urandom_range(3) == 0) ? $urandom_range(40, 300)
                                                             : $urandom_range(24));
      if (phase == 0 || $urandom_range(1))
        write_reg(CFG_CTCSS_ON, $urandom_range(1));
      if (phase == 0 || $urandom_range(1)) begin
        case ($urandom_range(3))
          0:       write_reg(CFG_CTCSS_STEP, 32'd0);
          1:       write_reg(CFG_CTCSS_STEP, 32'hFFFF_FFFF);
          default: write_reg(CFG_CTCSS_STEP, $urandom);
        endcase
      end
      cfg_wr_en <= 1'b0;
      for (k = 0; k < n; k++) begin
        quiet = (total >= 350 && total < 550);
        case ($urandom_range(19))
          0:       s = -16'sd32768;
          1:       s = 16'sd32767;
          2:       s = 16'sd0;
          3:       s = -16'sd1;
          4:       s = -16'sd256;
          5:       s = 16'sd255;
          default: s = 16'($urandom);
        endcase
        gap();
        send_sample(s, 1'b0, '0);
        total++;
      end
      phase++;
    end

    // Let the last ticks out, then give stray ones a chance to show
    drain();
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
